// File: src/ubxd_pkg.sv
// ----------------------------------------------------------------------------
// ubxd_pkg - shared types and constants of the UBX frame deframer
// Parse phases, message codes, result kinds and the frame record that the
// parser hands to the decoder.
// ----------------------------------------------------------------------------
package ubxd_pkg;

  // Parser phases, one-hot
  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN1    = 9'b000010000,
    PH_LEN2    = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CKA     = 9'b010000000,
    PH_CKB     = 9'b100000000
  } phase_e;

  localparam logic [7:0] SYNC1_BYTE = 8'hB5;
  localparam logic [7:0] SYNC2_BYTE = 8'h62;

  localparam logic [7:0] CLS_NAV    = 8'h01;
  localparam logic [7:0] ID_SAT     = 8'h35;
  localparam logic [7:0] ID_STATUS  = 8'h03;
  localparam logic [7:0] ID_PVT     = 8'h07;

  localparam logic [15:0] LEN_SAT_MIN    = 16'd8;
  localparam logic [15:0] LEN_STATUS_MIN = 16'd6;
  localparam logic [15:0] LEN_PVT_MIN    = 16'd24;
  localparam logic [15:0] LEN_PVT_FULL   = 16'd92;

  typedef enum logic [2:0] {
    KIND_OTHER    = 3'd0,
    KIND_SAT_LIST = 3'd1,
    KIND_STATUS   = 3'd2,
    KIND_PVT_SHORT = 3'd3,
    KIND_PVT_FULL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    QUAL_INVALID   = 3'd0,
    QUAL_GPS       = 3'd1,
    QUAL_DGPS      = 3'd2,
    QUAL_PPS       = 3'd3,
    QUAL_RTK_FIXED = 3'd4,
    QUAL_RTK_FLOAT = 3'd5
  } qual_e;

  // Completed frame: header, check verdict and the payload bytes decoded later
  typedef struct packed {
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic        ok;
    logic [31:0] tow;   // payload bytes 0..3, little endian
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [7:0]  b20;
    logic [7:0]  b21;
    logic [7:0]  b23;
  } frame_rec_t;

endpackage

// File: src/ubxd_parser.sv
// ----------------------------------------------------------------------------
// ubxd_parser - byte-level UBX frame parser
// Hunts the sync pair, tracks header and length, runs the Fletcher sums and
// captures the payload bytes needed for decoding into a frame record.
// ----------------------------------------------------------------------------
module ubxd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] rx_byte
  output logic                 rec_valid_o,
  input  logic                 rec_ready_i,
  output ubxd_pkg::frame_rec_t rec_o
);
  import ubxd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  cls_q, cls_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] taken_q, taken_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  cka_q, cka_d;
  logic        rec_valid_q;
  frame_rec_t  rec_q;

  // captured payload bytes
  logic [31:0] tow_q;
  logic [7:0]  b4_q, b5_q, b20_q, b21_q, b23_q;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] taken_inc;
  logic [15:0] len_full;
  logic        pay_wr;
  logic        done;

  // the second check byte waits while the record is still pending
  assign s_axis_tready_o = !(phase_q == PH_CKB && rec_valid_q && !rec_ready_i);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign b         = s_axis_tdata_i;
  assign sum_a_add = sum_a_q + b;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign taken_inc = taken_q + 16'd1;
  assign len_full  = {b, len_q[7:0]};
  assign pay_wr    = accept && (phase_q == PH_PAYLOAD);
  assign done      = accept && (phase_q == PH_CKB);

  always_comb begin
    phase_d = phase_q;
    cls_d   = cls_q;
    id_d    = id_q;
    len_d   = len_q;
    taken_d = taken_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    cka_d   = cka_q;
    if (accept) begin
      case (phase_q)
        PH_SYNC1: begin
          if (b == SYNC1_BYTE) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == SYNC2_BYTE) begin
            sum_a_d = '0;
            sum_b_d = '0;
            cls_d   = '0;
            id_d    = '0;
            len_d   = '0;
            taken_d = '0;
            phase_d = PH_CLASS;
          end else if (b != SYNC1_BYTE) begin
            phase_d = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          cls_d   = b;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PH_ID;
        end
        PH_ID: begin
          id_d    = b;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PH_LEN1;
        end
        PH_LEN1: begin
          len_d   = {8'd0, b};
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          phase_d = PH_LEN2;
        end
        PH_LEN2: begin
          len_d   = len_full;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          taken_d = '0;
          phase_d = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          taken_d = taken_inc;
          if (taken_inc >= len_q) phase_d = PH_CKA;
        end
        PH_CKA: begin
          cka_d   = b;
          phase_d = PH_CKB;
        end
        PH_CKB: begin
          phase_d = PH_SYNC1;
        end
        default: begin
          phase_d = PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      cls_q       <= '0;
      id_q        <= '0;
      len_q       <= '0;
      taken_q     <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      cka_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cls_q   <= cls_d;
      id_q    <= id_d;
      len_q   <= len_d;
      taken_q <= taken_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      cka_q   <= cka_d;
      if (done)             rec_valid_q <= 1'b1;
      else if (rec_ready_i) rec_valid_q <= 1'b0;
    end
  end

  // Only the bytes at fixed payload offsets that the decoder reads are kept
  always_ff @(posedge clk_i) begin
    if (pay_wr) begin
      if (taken_q == 16'd0)  tow_q[7:0]   <= b;
      if (taken_q == 16'd1)  tow_q[15:8]  <= b;
      if (taken_q == 16'd2)  tow_q[23:16] <= b;
      if (taken_q == 16'd3)  tow_q[31:24] <= b;
      if (taken_q == 16'd4)  b4_q  <= b;
      if (taken_q == 16'd5)  b5_q  <= b;
      if (taken_q == 16'd20) b20_q <= b;
      if (taken_q == 16'd21) b21_q <= b;
      if (taken_q == 16'd23) b23_q <= b;
    end
    if (done) begin
      rec_q.cls <= cls_q;
      rec_q.id  <= id_q;
      rec_q.len <= len_q;
      rec_q.ok  <= (cka_q == sum_a_q) && (b == sum_b_q);
      rec_q.tow <= tow_q;
      rec_q.b4  <= b4_q;
      rec_q.b5  <= b5_q;
      rec_q.b20 <= b20_q;
      rec_q.b21 <= b21_q;
      rec_q.b23 <= b23_q;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

endmodule

// File: src/ubxd_decoder.sv
// ----------------------------------------------------------------------------
// ubxd_decoder - message decode and result register
// Turns a completed frame record into a result item, keeps the satellite
// counts and last epoch time, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ubxd_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_valid_i,
  output logic                 rec_ready_o,
  input  ubxd_pkg::frame_rec_t rec_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] msg_class, [15:8] msg_id, [31:16] payload_len, [32] check_ok,
  // [35:33] kind, [67:36] time_of_week, [75:68] fix_kind, [76] diff_solution,
  // [79:77] fix_grade, [87:80] sats_used, [95:88] sats_visible,
  // [96] new_epoch, [103:97] zero
  output logic [103:0]         m_axis_tdata_o
);
  import ubxd_pkg::*;

  function automatic qual_e quality_code(logic [7:0] ft, logic [7:0] fl);
    logic [1:0] carrier;
    carrier = fl[7:6];
    if (ft == 8'd0 || ft == 8'd1 || !fl[0]) return QUAL_INVALID;
    if (ft == 8'd5)                         return QUAL_PPS;
    if (carrier == 2'd2)                    return QUAL_RTK_FIXED;
    if (carrier == 2'd1)                    return QUAL_RTK_FLOAT;
    if (fl[1])                              return QUAL_DGPS;
    return QUAL_GPS;
  endfunction

  logic        out_valid_q;
  logic        load;
  logic [7:0]  list_q, list_d;
  logic [7:0]  pvt_q, pvt_d;
  logic [31:0] epoch_t_q, epoch_t_d;

  kind_e       kind;
  qual_e       qual;
  logic [31:0] tow;
  logic [7:0]  fixk, used, visible;
  logic        diff, epoch;

  logic [7:0]  cls_q, id_q, fixk_q, used_q, visible_q;
  logic [15:0] len_q;
  logic        ok_q, diff_q, epoch_q;
  logic [2:0]  kind_q, qual_q;
  logic [31:0] tow_q;

  assign load        = rec_valid_i && (!out_valid_q || m_axis_tready_i);
  assign rec_ready_o = load;

  always_comb begin
    kind      = KIND_OTHER;
    qual      = QUAL_INVALID;
    tow       = '0;
    fixk      = '0;
    used      = '0;
    diff      = 1'b0;
    epoch     = 1'b0;
    list_d    = list_q;
    pvt_d     = pvt_q;
    epoch_t_d = epoch_t_q;
    if (rec_i.ok && rec_i.cls == CLS_NAV) begin
      if (rec_i.id == ID_SAT && rec_i.len >= LEN_SAT_MIN) begin
        kind   = KIND_SAT_LIST;
        used   = rec_i.b5;
        list_d = rec_i.b5;
      end else if (rec_i.id == ID_STATUS && rec_i.len >= LEN_STATUS_MIN) begin
        kind = KIND_STATUS;
        tow  = rec_i.tow;
        fixk = rec_i.b4;
        diff = rec_i.b5[0];
      end else if (rec_i.id == ID_PVT && rec_i.len >= LEN_PVT_MIN) begin
        kind  = KIND_PVT_SHORT;
        used  = rec_i.b23;
        pvt_d = rec_i.b23;
        if (rec_i.len >= LEN_PVT_FULL) begin
          kind = KIND_PVT_FULL;
          tow  = rec_i.tow;
          fixk = rec_i.b20;
          diff = rec_i.b21[1];
          qual = quality_code(rec_i.b20, rec_i.b21);
          if (rec_i.tow != epoch_t_q) begin
            epoch_t_d = rec_i.tow;
            epoch     = 1'b1;
          end
        end
      end
    end
    visible = (list_d != 8'd0) ? list_d : pvt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      list_q      <= '0;
      pvt_q       <= '0;
      epoch_t_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        list_q      <= list_d;
        pvt_q       <= pvt_d;
        epoch_t_q   <= epoch_t_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q     <= rec_i.cls;
      id_q      <= rec_i.id;
      len_q     <= rec_i.len;
      ok_q      <= rec_i.ok;
      kind_q    <= kind;
      tow_q     <= tow;
      fixk_q    <= fixk;
      diff_q    <= diff;
      qual_q    <= qual;
      used_q    <= used;
      visible_q <= visible;
      epoch_q   <= epoch;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, epoch_q, visible_q, used_q, qual_q, diff_q, fixk_q,
                            tow_q, kind_q, ok_q, len_q, id_q, cls_q};

  // decoded content only on good frames
  a_kind_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && kind_q != KIND_OTHER |-> ok_q)
    else $error("decoded kind on a frame with a bad check");

  a_qual_full_pvt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && qual_q != QUAL_INVALID |-> kind_q == KIND_PVT_FULL)
    else $error("fix grade outside a full pvt frame");

  a_epoch_full_pvt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && epoch_q |-> kind_q == KIND_PVT_FULL && tow_q == epoch_t_q)
    else $error("new epoch flag inconsistent with epoch tracking");

  a_epoch_time_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(epoch_t_q) && $stable(list_q) && $stable(pvt_q))
    else $error("tracking state changed without a frame");

endmodule

// File: src/ubx_frame_deframer.sv
// ----------------------------------------------------------------------------
// ubx_frame_deframer - UBX binary frame parser with Fletcher-8 check
// Top level: byte parser followed by the message decoder and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one received serial byte per transfer.
//   Master channel m_axis carries one result per completed frame, emitted on
//   the second check byte: header, check verdict and fields decoded from the
//   satellite list, nav status and pvt messages.
//   Throughput is one byte per cycle while s_axis_tready_o is high; every byte is
//   handled in the cycle it is taken. The frame record of the second check
//   byte is registered in the frame record register, then in the result
//   register, from which m_axis presents the result.
//   While a result waits on m_axis the block keeps taking bytes. Only the
//   second check byte of the following frame is held off, and only if the
//   frame record and the result register are both still full, so a stalled
//   receiver loses nothing.
//   Reset returns the parser to the sync hunt and clears the sums, the header
//   registers, the satellite counts and the last epoch time. Kept payload
//   bytes are not cleared; each is rewritten before a frame reads it.
// ----------------------------------------------------------------------------
module ubx_frame_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] rx_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] msg_class, [15:8] msg_id, [31:16] payload_len, [32] check_ok,
  // [35:33] kind, [67:36] time_of_week, [75:68] fix_kind, [76] diff_solution,
  // [79:77] fix_grade, [87:80] sats_used, [95:88] sats_visible,
  // [96] new_epoch, [103:97] zero
  output logic [103:0] m_axis_tdata_o
);
  import ubxd_pkg::*;

  logic       rec_valid;
  logic       rec_ready;
  frame_rec_t rec;

  ubxd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .rec_valid_o     (rec_valid),
    .rec_ready_i     (rec_ready),
    .rec_o           (rec)
  );

  ubxd_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (rec_valid),
    .rec_ready_o     (rec_ready),
    .rec_i           (rec),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// File: verif/tb_ubx_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ubx_frame_deframer - self-checking bench for the UBX frame deframer
// Streams sync noise and UBX frames byte by byte into s_axis. Each accepted
// byte goes through a parser and decoder held in a tracker class, which
// queues the result of every completed frame. Results taken from m_axis are
// checked field by field against that queue. The sender works in bursts and
// the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_ubx_frame_deframer;
  import ubxd_pkg::*;

  localparam int          HEAD_BYTES  = 96;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int          HOLD_CYCLES = 500;

  // receiver fix type codes and carrier solution codes used by the quality map
  localparam logic [7:0] FIX_NONE      = 8'd0;
  localparam logic [7:0] FIX_DR_ONLY   = 8'd1;
  localparam logic [7:0] FIX_TIME_ONLY = 8'd5;
  localparam logic [1:0] CARR_FLOAT    = 2'd1;
  localparam logic [1:0] CARR_FIXED    = 2'd2;

  typedef enum int {FLAW_NONE, FLAW_BAD_CKA, FLAW_BAD_CKB, FLAW_CUT} flaw_e;
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE} rx_mode_e;

  // Same layout as m_axis_tdata_o, lowest field last
  typedef struct packed {
    logic [6:0]  pad;
    logic        new_epoch;
    logic [7:0]  visible;
    logic [7:0]  used;
    qual_e       qual;
    logic        diff;
    logic [7:0]  fixk;
    logic [31:0] tow;
    kind_e       kind;
    logic        ok;
    logic [15:0] len;
    logic [7:0]  id;
    logic [7:0]  cls;
  } frame_result_t;

  class ubx_result_tracker;
    phase_e        phase;
    logic [7:0]    cls, id, ck_first, sum_a, sum_b, list_sats, pvt_sats;
    logic [15:0]   len, taken;
    logic [31:0]   epoch_tow;
    logic [7:0]    head [HEAD_BYTES];
    frame_result_t awaited_results[$];
    int            errors;
    int            results_seen;

    function new();
      phase        = PH_SYNC1;
      cls          = '0;
      id           = '0;
      ck_first     = '0;
      sum_a        = '0;
      sum_b        = '0;
      list_sats    = '0;
      pvt_sats     = '0;
      len          = '0;
      taken        = '0;
      epoch_tow    = '0;
      errors       = 0;
      results_seen = 0;
      foreach (head[i]) head[i] = '0;
    endfunction

    function void fold(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    // One accepted byte through the parser; a second check byte queues a result
    function void take_byte(logic [7:0] b);
      frame_result_t r;
      logic [1:0]    carrier;
      case (phase)
        PH_SYNC1: begin
          if (b == SYNC1_BYTE) phase = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == SYNC2_BYTE) begin
            sum_a = '0;
            sum_b = '0;
            cls   = '0;
            id    = '0;
            len   = '0;
            taken = '0;
            phase = PH_CLASS;
          end else if (b != SYNC1_BYTE) begin
            phase = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          cls = b;
          fold(b);
          phase = PH_ID;
        end
        PH_ID: begin
          id = b;
          fold(b);
          phase = PH_LEN1;
        end
        PH_LEN1: begin
          len = {8'h00, b};
          fold(b);
          phase = PH_LEN2;
        end
        PH_LEN2: begin
          len[15:8] = b;
          fold(b);
          taken = '0;
          phase = (len == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (taken < HEAD_BYTES) head[taken] = b;
          fold(b);
          taken = taken + 16'd1;
          if (taken >= len) phase = PH_CKA;
        end
        PH_CKA: begin
          ck_first = b;
          phase = PH_CKB;
        end
        PH_CKB: begin
          r      = '0;
          r.cls  = cls;
          r.id   = id;
          r.len  = len;
          r.ok   = (ck_first == sum_a) && (b == sum_b);
          r.kind = KIND_OTHER;
          r.qual = QUAL_INVALID;
          if (r.ok && cls == CLS_NAV) begin
            if (id == ID_SAT && len >= LEN_SAT_MIN) begin
              r.kind    = KIND_SAT_LIST;
              r.used    = head[5];
              list_sats = head[5];
            end else if (id == ID_STATUS && len >= LEN_STATUS_MIN) begin
              r.kind = KIND_STATUS;
              r.tow  = {head[3], head[2], head[1], head[0]};
              r.fixk = head[4];
              r.diff = head[5][0];
            end else if (id == ID_PVT && len >= LEN_PVT_MIN) begin
              r.kind   = KIND_PVT_SHORT;
              r.used   = head[23];
              pvt_sats = head[23];
              if (len >= LEN_PVT_FULL) begin
                r.kind  = KIND_PVT_FULL;
                r.tow   = {head[3], head[2], head[1], head[0]};
                r.fixk  = head[20];
                r.diff  = head[21][1];
                carrier = head[21][7:6];
                if (head[20] == FIX_NONE || head[20] == FIX_DR_ONLY || !head[21][0])
                  r.qual = QUAL_INVALID;
                else if (head[20] == FIX_TIME_ONLY) r.qual = QUAL_PPS;
                else if (carrier == CARR_FIXED)     r.qual = QUAL_RTK_FIXED;
                else if (carrier == CARR_FLOAT)     r.qual = QUAL_RTK_FLOAT;
                else if (head[21][1])               r.qual = QUAL_DGPS;
                else                                r.qual = QUAL_GPS;
                if (r.tow != epoch_tow) begin
                  epoch_tow   = r.tow;
                  r.new_epoch = 1'b1;
                end
              end
            end
          end
          r.visible = (list_sats != 8'd0) ? list_sats : pvt_sats;
          awaited_results.push_back(r);
          phase = PH_SYNC1;
        end
        default: phase = PH_SYNC1;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_seen, name, got_v, exp_v));
    endtask

    task check_result(logic [103:0] data);
      frame_result_t got, exp;
      got = frame_result_t'(data);
      results_seen++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result %0d with no frame awaiting it: %h", results_seen, data));
        return;
      end
      exp = awaited_results.pop_front();
      check_field("msg_class",     got.cls,       exp.cls);
      check_field("msg_id",        got.id,        exp.id);
      check_field("payload_len",   got.len,       exp.len);
      check_field("check_ok",      got.ok,        exp.ok);
      check_field("kind",          got.kind,      exp.kind);
      check_field("time_of_week",  got.tow,       exp.tow);
      check_field("fix_kind",      got.fixk,      exp.fixk);
      check_field("diff_solution", got.diff,      exp.diff);
      check_field("fix_grade",     got.qual,      exp.qual);
      check_field("sats_used",     got.used,      exp.used);
      check_field("sats_visible",  got.visible,   exp.visible);
      check_field("new_epoch",     got.new_epoch, exp.new_epoch);
      check_field("padding",       got.pad,       exp.pad);
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [103:0] m_axis_tdata_o;

  ubx_result_tracker tracker;
  int                burst_left;
  int                frame_bytes;
  int unsigned       cycle_count;
  logic [31:0]       shp_tow;

  ubx_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ubx_frame_deframer: mismatch");
      $finish;
    end
  end

  // Transfers seen on both channels, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) tracker.take_byte(s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) tracker.check_result(m_axis_tdata_o);
    end
  end

  // Receiver: changing stall modes, plus one long hold-off once results flow
  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    bit       held;
    mode      = RX_STREAM;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    held      = 1'b0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && tracker.results_seen >= 12) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(32, 160);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_STREAM: m_axis_tready_i <= 1'b1;
          RX_COIN:   m_axis_tready_i <= 1'($urandom_range(0, 1));
          default:   m_axis_tready_i <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Frame with Fletcher sums, possibly flawed or cut short; the payload fields the decoder reads are shaped
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input flaw_e flaw);
    logic [7:0]  hdr [4];
    logic [7:0]  ck_a, ck_b, b, shp_fix, shp_flags, shp_b5;
    int unsigned cut;
    hdr  = '{cls, id, len[7:0], len[15:8]};
    ck_a = '0;
    ck_b = '0;
    cut  = (flaw == FLAW_CUT && len != 16'd0) ? $urandom_range(4, 3 + len) : 0;
    // keeping the previous time of week now and then gives repeated epochs
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       shp_tow = '0;
        1:       shp_tow = '1;
        default: shp_tow = $urandom;
      endcase
    end
    shp_fix   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    shp_flags = 8'($urandom);
    shp_b5    = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    send_byte(SYNC1_BYTE);
    send_byte(SYNC2_BYTE);
    for (int unsigned i = 0; i < 4 + len; i++) begin
      if (cut != 0 && i == cut) return;
      if (i < 4) begin
        b = hdr[i];
      end else begin
        case (i - 4)
          0, 1, 2, 3: b = shp_tow[8*(i-4) +: 8];
          5:          b = shp_b5;
          20:         b = shp_fix;
          21:         b = shp_flags;
          default:    b = 8'($urandom);
        endcase
      end
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b);
    end
    if (flaw == FLAW_BAD_CKA) ck_a ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == FLAW_BAD_CKB) ck_b ^= 8'(1 << $urandom_range(0, 7));
    send_byte(ck_a);
    send_byte(ck_b);
    frame_bytes += 8 + len;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          pick;
    int          flaw_pick;
    int          noise_len;
    logic [7:0]  f_cls, f_id, nb;
    logic [15:0] f_len;
    flaw_e       flaw;
    tracker     = new();
    burst_left  = 0;
    frame_bytes = 0;
    cycle_count = 0;
    shp_tow     = '0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Noise, a sync byte followed by junk, a repeated sync byte, empty frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC1_BYTE);
    send_byte(8'h00);
    send_byte(SYNC1_BYTE);
    send_frame(8'hFF, 8'h00, 16'd0, FLAW_NONE);
    send_frame(8'h00, 8'hFF, 16'd0, FLAW_BAD_CKB);
    wait_drained();

    while (frame_bytes < 1600) begin
      if ($urandom_range(0, 7) == 0) begin
        noise_len = $urandom_range(1, 5);
        repeat (noise_len) begin
          nb = ($urandom_range(0, 2) == 0) ? SYNC1_BYTE : 8'($urandom);
          // never complete a sync pair from noise
          if (nb == SYNC2_BYTE) nb = 8'h63;
          send_byte(nb);
        end
      end
      pick  = $urandom_range(0, 99);
      f_cls = CLS_NAV;
      if (pick < 15) begin
        f_id  = ID_SAT;
        f_len = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 7))
                                            : 16'($urandom_range(8, 20));
      end else if (pick < 30) begin
        f_id  = ID_STATUS;
        f_len = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 5))
                                            : 16'($urandom_range(6, 16));
      end else if (pick < 45) begin
        f_id  = ID_PVT;
        f_len = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 23))
                                            : 16'($urandom_range(24, 91));
      end else if (pick < 62) begin
        f_id  = ID_PVT;
        f_len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(96, 160))
                                            : 16'($urandom_range(92, 95));
      end else if (pick < 97) begin
        f_cls = $urandom_range(0, 1) ? CLS_NAV : 8'($urandom);
        f_id  = 8'($urandom);
        f_len = 16'($urandom_range(0, 12));
      end else begin
        f_cls = 8'($urandom);
        f_id  = 8'($urandom);
        f_len = 16'($urandom_range(200, 400));
      end
      flaw_pick = $urandom_range(0, 19);
      case (flaw_pick)
        0:       flaw = FLAW_BAD_CKA;
        1:       flaw = FLAW_BAD_CKB;
        2:       flaw = FLAW_CUT;
        default: flaw = FLAW_NONE;
      endcase
      send_frame(f_cls, f_id, f_len, flaw);
    end

    // Long full pvt frame, well past the kept payload bytes
    send_frame(CLS_NAV, ID_PVT, 16'd300, FLAW_NONE);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("ubx_frame_deframer: match");
    end else begin
      $display("ubx_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule
